// ===== sv/sfds_pkg.sv =====
// ----------------------------------------------------------------------------
// sfds_pkg
// Shared constants, types and helpers of the speed-from-distance smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package sfds_pkg;

   localparam int MAX_WINDOW  = 1024;
   localparam int SLOT_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W       = SLOT_W + 1;
   localparam int CFG_W       = 11;
   localparam int SPEED_W     = 32;
   localparam int SUM_W       = SPEED_W + SLOT_W;
   localparam int DIV_W       = (SUM_W > 44) ? SUM_W : 44;
   localparam int DIVISOR_W   = 32;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int KPH_SCALE   = 3600;

   typedef logic signed [SPEED_W-1:0] speed_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic div1_start;
      logic raw;
      logic acc;
      logic div2_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
   } status_type;

   // Saturate a sign and magnitude pair to a signed 32-bit speed.
   function automatic speed_type sat_speed(input logic neg, input logic [DIV_W-1:0] mag);
      speed_type res;
      if (!neg) begin
         if (mag > DIV_W'(32'h7FFF_FFFF)) begin
            res = 32'sh7FFF_FFFF;
         end else begin
            res = speed_type'(mag[SPEED_W-1:0]);
         end
      end else begin
         if (mag > DIV_W'(32'h8000_0000)) begin
            res = speed_type'(32'h8000_0000);
         end else begin
            res = speed_type'(~mag[SPEED_W-1:0] + 32'd1);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sfds_req_if.sv =====
// ----------------------------------------------------------------------------
// sfds_req_if
// Request channel: one timed distance sample per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfds_req_if
   import sfds_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic        first_sample;
   logic [31:0] sample_time_ms;
   logic [31:0] distance_mm;
   speed_type   reported_speed;

   modport source (output valid, output first_sample, output sample_time_ms,
                   output distance_mm, output reported_speed, input ready);
   modport sink   (input valid, input first_sample, input sample_time_ms,
                   input distance_mm, input reported_speed, output ready);
endinterface

`default_nettype wire

// ===== sv/sfds_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sfds_rsp_if
// Response channel: smoothed speed and change flag per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfds_rsp_if
   import sfds_pkg::*;
   ();
   logic      valid;
   logic      ready;
   speed_type smoothed_speed;
   logic      speed_changed;

   modport source (output valid, output smoothed_speed, output speed_changed,
                   input ready);
   modport sink   (input valid, input smoothed_speed, input speed_changed,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/speed_from_distance_smoother.sv =====
// ----------------------------------------------------------------------------
// speed_from_distance_smoother
// Distance-derived speed with a boxcar moving average over a set window.
// ----------------------------------------------------------------------------
// Each request on req_bus carries a sample time, cumulative distance and the
// device speed; each yields exactly one response on rsp_bus with the smoothed
// speed in milli-kph and a flag that it differs from the device speed.
// The window length is written through csr_write_enable/csr_write_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce; a write restarts the average. Each request runs the
// shared bit-serial divider twice, once for the raw speed and once for the
// average. A new request is taken once the previous one has been loaded
// into the response register, so a stalled response does not hold up the
// next request's work; the block then waits at its end until the response
// register is taken.
// Reset (synchronous, active high) clears history counters, running sum,
// previous sample and sets the window to one sample. The history RAM itself
// is not cleared: entries are read only after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_from_distance_smoother
   import sfds_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   sfds_req_if.sink              req_bus,
   sfds_rsp_if.source            rsp_bus,
   input  wire logic             csr_write_enable,
   input  wire logic [CFG_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   sfds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sfds_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_first_sample   (req_bus.first_sample),
      .req_sample_time_ms (req_bus.sample_time_ms),
      .req_distance_mm    (req_bus.distance_mm),
      .req_reported_speed (req_bus.reported_speed),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_smoothed_speed (rsp_bus.smoothed_speed),
      .rsp_speed_changed  (rsp_bus.speed_changed)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while previous one still in work");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response register overwritten before taken");

   a_div_in_work: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_bus.ready)
      else $error("divider running while controller idle");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_bus.valid)
      else $error("response not presented after load");

endmodule

`default_nettype wire

// ===== sv/sfds_ram.sv =====
// ----------------------------------------------------------------------------
// sfds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/sfds_div.sv =====
// ----------------------------------------------------------------------------
// sfds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfds_div
   import sfds_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_W-1:0]     dividend,
   input  wire logic [DIVISOR_W-1:0] divisor,
   output      logic                 busy,
   output      logic                 done,
   output      logic [DIV_W-1:0]     quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] den_ff;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;
   logic [DIVISOR_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      fits   = (trial >= {1'b0, den_ff});
      rem_in = fits ? DIVISOR_W'(trial - {1'b0, den_ff}) : trial[DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && (cnt_ff == DIV_CNT_W'(DIV_W - 1))) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sv/sfds_dp.sv =====
// ----------------------------------------------------------------------------
// sfds_dp
// Datapath: sample registers, raw speed, history RAM, running sum, divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sfds_dp
   import sfds_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output      status_type       status,
   input  wire logic             req_first_sample,
   input  wire logic [31:0]      req_sample_time_ms,
   input  wire logic [31:0]      req_distance_mm,
   input  wire speed_type        req_reported_speed,
   input  wire logic             csr_write_enable,
   input  wire logic [CFG_W-1:0] csr_write_data,
   output      speed_type        rsp_smoothed_speed,
   output      logic             rsp_speed_changed
);

   logic [CFG_W-1:0]     window_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [CNT_W-1:0]     seen_ff;
   logic [31:0]          prev_time_ff;
   logic [31:0]          prev_dist_ff;

   logic [31:0]          time_ff;
   logic [31:0]          dist_ff;
   speed_type            rep_ff;
   logic                 dt_pos_ff;
   logic [31:0]          dt_ff;
   logic                 dd_neg_ff;
   logic [31:0]          dd_abs_ff;
   logic [DIV_W-1:0]     num_mag_ff;
   speed_type            raw_ff;
   logic [CNT_W-1:0]     n_ff;
   logic                 avg_neg_ff;
   speed_type            out_speed_ff;
   logic                 out_changed_ff;

   logic [CNT_W-1:0]     w_eff;
   logic [CNT_W-1:0]     seen_inc;
   speed_type            hist_rd;
   logic signed [SUM_W-1:0] sub_in;
   logic signed [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0]     sum_mag;
   logic [DIV_W-1:0]     div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [DIV_W-1:0]     div_quotient;
   logic                 div_busy;
   logic                 div_done;
   speed_type            raw_in;
   speed_type            avg_in;

   always_comb begin
      if (window_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         w_eff = CNT_W'(MAX_WINDOW);
      end else begin
         w_eff = CNT_W'(window_ff);
      end
      seen_inc = seen_ff + CNT_W'(1);
      sub_in   = (seen_ff >= w_eff) ? {{(SUM_W-SPEED_W){hist_rd[SPEED_W-1]}}, hist_rd} : '0;
      sum_in   = sum_ff - sub_in + {{(SUM_W-SPEED_W){raw_ff[SPEED_W-1]}}, raw_ff};
      sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(~sum_ff + SUM_W'(1)) : SUM_W'(sum_ff);
      if (cmd.div1_start) begin
         div_dividend = num_mag_ff;
         div_divisor  = dt_ff;
      end else begin
         div_dividend = DIV_W'(sum_mag);
         div_divisor  = DIVISOR_W'(n_ff);
      end
      if (dt_pos_ff) begin
         raw_in = sat_speed(dd_neg_ff, div_quotient);
      end else if (time_ff == '0) begin
         raw_in = '0;
      end else begin
         raw_in = rep_ff;
      end
      avg_in = sat_speed(avg_neg_ff, div_quotient);
   end

   // running state
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= CFG_W'(1);
         sum_ff       <= '0;
         slot_ff      <= '0;
         seen_ff      <= '0;
         prev_time_ff <= '0;
         prev_dist_ff <= '0;
      end else if (csr_write_enable) begin
         window_ff <= csr_write_data;
         sum_ff    <= '0;
         slot_ff   <= '0;
         seen_ff   <= '0;
      end else if (cmd.load && req_first_sample) begin
         sum_ff       <= '0;
         slot_ff      <= '0;
         seen_ff      <= '0;
         prev_time_ff <= '0;
         prev_dist_ff <= '0;
      end else if (cmd.acc) begin
         sum_ff       <= sum_in;
         slot_ff      <= (CNT_W'(slot_ff) >= w_eff - CNT_W'(1)) ? '0 : slot_ff + SLOT_W'(1);
         seen_ff      <= (seen_ff < w_eff) ? seen_inc : seen_ff;
         prev_time_ff <= time_ff;
         prev_dist_ff <= dist_ff;
      end
   end

   // per-request payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_ff <= req_sample_time_ms;
         dist_ff <= req_distance_mm;
         rep_ff  <= req_reported_speed;
      end
      if (cmd.prep) begin
         dt_pos_ff <= (time_ff > prev_time_ff);
         dt_ff     <= time_ff - prev_time_ff;
         dd_neg_ff <= (dist_ff < prev_dist_ff);
         dd_abs_ff <= (dist_ff < prev_dist_ff) ? prev_dist_ff - dist_ff
                                               : dist_ff - prev_dist_ff;
      end
      if (cmd.mul) begin
         num_mag_ff <= DIV_W'(dd_abs_ff) * DIV_W'(KPH_SCALE);
      end
      if (cmd.raw) begin
         raw_ff <= raw_in;
      end
      if (cmd.acc) begin
         n_ff <= (seen_inc < w_eff) ? seen_inc : w_eff;
      end
      if (cmd.div2_start) begin
         avg_neg_ff <= sum_ff[SUM_W-1];
      end
      if (cmd.emit) begin
         out_speed_ff   <= avg_in;
         out_changed_ff <= (avg_in != rep_ff);
      end
   end

   sfds_ram #(
      .WIDTH (SPEED_W),
      .DEPTH (MAX_WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (cmd.acc),
      .wr_addr (slot_ff),
      .wr_data (raw_ff),
      .rd_en   (cmd.prep),
      .rd_addr (slot_ff),
      .rd_data (hist_rd)
   );

   sfds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div1_start | cmd.div2_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.div_busy   = div_busy;
   assign status.div_done   = div_done;
   assign rsp_smoothed_speed = out_speed_ff;
   assign rsp_speed_changed  = out_changed_ff;

endmodule

`default_nettype wire

// ===== sv/sfds_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfds_ctrl
// Controller: sequences one request through the datapath, owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sfds_ctrl
   import sfds_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      cmd_type    cmd,
   input  wire status_type status
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PREP = 4'd1;
   localparam logic [3:0] S_MUL  = 4'd2;
   localparam logic [3:0] S_ST1  = 4'd3;
   localparam logic [3:0] S_W1   = 4'd4;
   localparam logic [3:0] S_RAW  = 4'd5;
   localparam logic [3:0] S_ACC  = 4'd6;
   localparam logic [3:0] S_ST2  = 4'd7;
   localparam logic [3:0] S_W2   = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ST1;
         end
         S_ST1: begin
            cmd.div1_start = 1'b1;
            state_in       = S_W1;
         end
         S_W1: begin
            if (status.div_done) begin
               state_in = S_RAW;
            end
         end
         S_RAW: begin
            cmd.raw  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_ST2;
         end
         S_ST2: begin
            cmd.div2_start = 1'b1;
            state_in       = S_W2;
         end
         S_W2: begin
            if (status.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
